// File: src/rdc_pkg.sv
// ----------------------------------------------------------------------------
// Radix digit converter package
// Widths, digit encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IN_W        = 32;
  localparam int unsigned BASE_W      = 6;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned BITCNT_W    = $clog2(VALUE_WIDTH);
  localparam int unsigned SP_W        = $clog2(VALUE_WIDTH + 1);

  localparam logic [BASE_W-1:0] MIN_BASE = BASE_W'(2);
  localparam logic [BASE_W-1:0] MAX_BASE = BASE_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A_OFFS = CHAR_W'(55);  // 'A' - 10
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic in_bad;     // base of the offered item is out of range
    logic div_last;   // current divide step produces the digit
    logic quot_zero;  // quotient after this step is zero
    logic out_free;   // output register can take a digit
    logic stack_one;  // one digit left to emit
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DEC_DIGITS) begin
      return CHAR_ZERO + dx;
    end
    return CHAR_A_OFFS + dx;
  endfunction

endpackage

// File: src/rdc_datapath.sv
// ----------------------------------------------------------------------------
// Radix digit converter datapath
// Bit-serial restoring divider, digit stack and output register.
// ----------------------------------------------------------------------------
module rdc_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rdc_pkg::cmd_t                cmd_i,
  output rdc_pkg::status_t             status_o,
  input  logic [rdc_pkg::IN_W-1:0]     value_i,
  input  logic [rdc_pkg::BASE_W-1:0]   base_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [rdc_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                         last_o,
  output logic                         bad_base_o
);

  localparam int unsigned VW = rdc_pkg::VALUE_WIDTH;

  // Dividend shifts out at the top while quotient bits enter at the bottom
  logic [VW-1:0]                    dvd_q, dvd_d;
  logic [rdc_pkg::DIGIT_W-1:0]      rem_q, rem_d;
  logic [rdc_pkg::BASE_W-1:0]       base_q;
  logic                             bad_q;
  logic [rdc_pkg::BITCNT_W-1:0]     bit_cnt_q;
  logic [rdc_pkg::SP_W-1:0]         sp_q;
  logic [rdc_pkg::SP_W-1:0]         sp_m1;
  logic [rdc_pkg::DIGIT_W-1:0]      stack_q [VW];
  logic [rdc_pkg::DIGIT_W:0]        trial;
  logic                             qbit;
  logic                             in_bad;

  logic                             out_valid_q;
  logic [rdc_pkg::CHAR_W-1:0]       out_char_q;
  logic                             out_last_q;
  logic                             out_bad_q;

  assign in_bad = (base_i < rdc_pkg::MIN_BASE) || (base_i > rdc_pkg::MAX_BASE);

  assign trial = {rem_q, dvd_q[VW-1]};
  assign qbit  = (trial >= {1'b0, base_q});
  assign rem_d = qbit ? rdc_pkg::DIGIT_W'(trial - {1'b0, base_q})
                      : rdc_pkg::DIGIT_W'(trial);
  assign dvd_d = {dvd_q[VW-2:0], qbit};
  assign sp_m1 = sp_q - rdc_pkg::SP_W'(1);

  assign status_o.in_bad    = in_bad;
  assign status_o.div_last  = (bit_cnt_q == rdc_pkg::BITCNT_W'(VW - 1));
  assign status_o.quot_zero = (dvd_d == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.stack_one = (sp_q == rdc_pkg::SP_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
      sp_q      <= '0;
      bad_q     <= 1'b0;
    end else if (cmd_i.load) begin
      bit_cnt_q <= '0;
      bad_q     <= in_bad;
      // A bad base goes straight to the stack as a single '0'
      sp_q      <= in_bad ? rdc_pkg::SP_W'(1) : '0;
    end else if (cmd_i.div_step) begin
      if (bit_cnt_q == rdc_pkg::BITCNT_W'(VW - 1)) begin
        bit_cnt_q <= '0;
        sp_q      <= sp_q + rdc_pkg::SP_W'(1);
      end else begin
        bit_cnt_q <= bit_cnt_q + rdc_pkg::BITCNT_W'(1);
      end
    end else if (cmd_i.pop) begin
      sp_q <= sp_m1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dvd_q      <= VW'(value_i);
      rem_q      <= '0;
      base_q     <= base_i;
      stack_q[0] <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_d;
      if (bit_cnt_q == rdc_pkg::BITCNT_W'(VW - 1)) begin
        rem_q <= '0;
        stack_q[sp_q[rdc_pkg::BITCNT_W-1:0]] <= rem_d;
      end else begin
        rem_q <= rem_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      out_char_q <= rdc_pkg::digit_to_char(stack_q[sp_m1[rdc_pkg::BITCNT_W-1:0]]);
      out_last_q <= (sp_q == rdc_pkg::SP_W'(1));
      out_bad_q  <= bad_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_o       = out_last_q;
  assign bad_base_o   = out_bad_q;

endmodule

// File: src/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// Radix digit converter controller
// Sequences load, per-digit division and most-significant-first emission.
// ----------------------------------------------------------------------------
module rdc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rdc_pkg::status_t  status_i,
  output rdc_pkg::cmd_t     cmd_o
);

  rdc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rdc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_bad ? rdc_pkg::ST_EMIT : rdc_pkg::ST_DIV;
        end
      end
      rdc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last && status_i.quot_zero) begin
          state_d = rdc_pkg::ST_EMIT;
        end
      end
      rdc_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.pop = 1'b1;
          if (status_i.stack_one) begin
            state_d = rdc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = rdc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/radix_digit_converter_unit.sv
// ----------------------------------------------------------------------------
// Radix digit converter
// Converts an unsigned value to ASCII digits in base 2..36, MSD first.
// ----------------------------------------------------------------------------
// One item at a time. Each digit takes a full pass of the bit-serial restoring
// divider, and digits are then emitted from a stack at one per cycle while the
// output register is free. A bad base gives a single '0' with bad_base set. The
// next item is taken once the last digit sits in the output register.
module radix_digit_converter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rdc_pkg::IN_W-1:0]    value_i,
  input  logic [rdc_pkg::BASE_W-1:0]  base_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rdc_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                        last_o,
  output logic                        bad_base_o
);

  rdc_pkg::cmd_t    cmd;
  rdc_pkg::status_t status;

  rdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rdc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .value_i      (value_i),
    .base_i       (base_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .digit_char_o (digit_char_o),
    .last_o       (last_o),
    .bad_base_o   (bad_base_o)
  );

endmodule
